FILE: rtl/ps2m_pkg.sv
package ps2m_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned BOUND_W = 10;
	localparam int unsigned SLOW_W  = 5;
	localparam int unsigned CFG_W   = 10;
	localparam int unsigned CFGI_W  = 2;
	localparam int unsigned POS_W   = 15;
	localparam int unsigned CUR_W   = 10;
	localparam int unsigned BTN_N   = 3;
	localparam int unsigned BIDX_W  = 2;

	localparam logic [POS_W-1:0] POS_MAX = POS_W'(1023 * 31);

	localparam logic [CFGI_W-1:0] REG_BOUND_X   = 2'd0;
	localparam logic [CFGI_W-1:0] REG_BOUND_Y   = 2'd1;
	localparam logic [CFGI_W-1:0] REG_SLOWNESS  = 2'd2;
	localparam logic [CFGI_W-1:0] REG_EV_ENABLE = 2'd3;

	localparam logic [BOUND_W-1:0] BOUND_X_RST = 10'd79;
	localparam logic [BOUND_W-1:0] BOUND_Y_RST = 10'd49;
	localparam logic [SLOW_W-1:0]  SLOW_RST    = 5'd10;
	localparam logic [POS_W-1:0]   POS_X_RST   = 15'd40;
	localparam logic [POS_W-1:0]   POS_Y_RST   = 15'd25;

	localparam logic EV_BUTTON = 1'b0;
	localparam logic EV_MOVE   = 1'b1;

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_DX     = 2'd1;
	localparam logic [1:0] PH_DY     = 2'd2;

	localparam int unsigned HDR_SYNC_BIT = 3;
	localparam int unsigned HDR_XSIGN    = 4;
	localparam int unsigned HDR_YSIGN    = 5;

endpackage

FILE: rtl/ps2m_if.sv
interface ps2m_in_if import ps2m_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              from_aux;

	modport source (output valid, data_byte, from_aux, input ready);
	modport sink   (input valid, data_byte, from_aux, output ready);
endinterface

interface ps2m_out_if import ps2m_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              event_kind;
	logic [BIDX_W-1:0] button_index;
	logic              button_pressed;
	logic [CUR_W-1:0]  cursor_x;
	logic [CUR_W-1:0]  cursor_y;
	logic              last_event;

	modport source (output valid, event_kind, button_index, button_pressed,
		cursor_x, cursor_y, last_event, input ready);
	modport sink   (input valid, event_kind, button_index, button_pressed,
		cursor_x, cursor_y, last_event, output ready);
endinterface

FILE: rtl/ps2_mouse_packet_decoder.sv
// a header byte with changed buttons, events on, leads to ST_BTN, which offers one button event
// per cycle while the sink takes them; with events on, the third packet byte leads through
// ST_CLAMP_X, ST_CLAMP_Y, ST_DIV_GO, ST_DIV_WAIT and ST_MOVE to a move event; input is taken
// only in ST_IDLE, so the two 15-step bit-serial dividers that scale the positions hold it
// reset: asynchronous, all registers return at once to their power-up values, no clearing pass
module ps2_mouse_packet_decoder import ps2m_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	ps2m_in_if.sink            in_ch,
	ps2m_out_if.source         out_ch,
	input  logic               cfg_we,
	input  logic [CFGI_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BTN,
		ST_CLAMP_X,
		ST_CLAMP_Y,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_MOVE
	} state_t;

	state_t state_q;

	logic [BOUND_W-1:0] bound_x_q;
	logic [BOUND_W-1:0] bound_y_q;
	logic [SLOW_W-1:0]  slow_q;
	logic               en_q;

	logic [1:0]         phase_q;
	logic [BYTE_W-1:0]  hdr_q;
	logic [BYTE_W-1:0]  dx_q;
	logic [BYTE_W-1:0]  dy_q;
	logic [BTN_N-1:0]   lv_q;
	logic [BTN_N-1:0]   chg_q;
	logic [POS_W-1:0]   pos_x_q;
	logic [POS_W-1:0]   pos_y_q;

	logic               out_v_q;
	logic               kind_q;
	logic [BIDX_W-1:0]  bidx_q;
	logic               press_q;
	logic [CUR_W-1:0]   cx_q;
	logic [CUR_W-1:0]   cy_q;
	logic               last_q;

	logic               in_fire;
	logic               out_free;
	logic               out_load;
	logic [SLOW_W-1:0]  slow_eff;
	logic [BOUND_W-1:0] bound_sel;
	logic [POS_W-1:0]   lim;
	logic [POS_W+1:0]   sum;
	logic [POS_W-1:0]   clamped;
	logic [BIDX_W-1:0]  btn_idx;
	logic [BTN_N-1:0]   chg_rest;
	logic [BTN_N-1:0]   new_chg;

	logic               div_go;
	logic               busy_x;
	logic               busy_y;
	logic [POS_W-1:0]   quo_x;
	logic [POS_W-1:0]   quo_y;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign out_free    = !out_v_q || out_ch.ready;
	assign out_load    = ((state_q == ST_BTN) || (state_q == ST_MOVE)) && out_free;
	assign div_go      = (state_q == ST_DIV_GO);
	assign new_chg     = lv_q ^ in_ch.data_byte[BTN_N-1:0];

	always_comb begin
		slow_eff  = (slow_q == '0) ? SLOW_W'(1) : slow_q;
		bound_sel = (state_q == ST_CLAMP_Y) ? bound_y_q : bound_x_q;
		lim       = POS_W'(POS_W'(bound_sel) * POS_W'(slow_eff));
		if (state_q == ST_CLAMP_Y) begin
			sum = {2'b00, pos_y_q} - {{(POS_W+2-BYTE_W){hdr_q[HDR_YSIGN]}}, dy_q};
		end else begin
			sum = {2'b00, pos_x_q} + {{(POS_W+2-BYTE_W){hdr_q[HDR_XSIGN]}}, dx_q};
		end
		if (sum[POS_W+1]) begin
			clamped = '0;
		end else if (sum[POS_W:0] > {1'b0, lim}) begin
			clamped = lim;
		end else begin
			clamped = sum[POS_W-1:0];
		end
		if (chg_q[0]) begin
			btn_idx = BIDX_W'(0);
		end else if (chg_q[1]) begin
			btn_idx = BIDX_W'(1);
		end else begin
			btn_idx = BIDX_W'(2);
		end
		chg_rest = chg_q & ~(BTN_N'(1) << btn_idx);
	end

	ps2m_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (pos_x_q),
		.divisor  (slow_eff),
		.busy     (busy_x),
		.quotient (quo_x)
	);

	ps2m_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (pos_y_q),
		.divisor  (slow_eff),
		.busy     (busy_y),
		.quotient (quo_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bound_x_q <= BOUND_X_RST;
			bound_y_q <= BOUND_Y_RST;
			slow_q    <= SLOW_RST;
			en_q      <= 1'b0;
			phase_q   <= PH_HEADER;
			hdr_q     <= '0;
			dx_q      <= '0;
			dy_q      <= '0;
			lv_q      <= '0;
			chg_q     <= '0;
			pos_x_q   <= POS_X_RST;
			pos_y_q   <= POS_Y_RST;
			out_v_q   <= 1'b0;
			kind_q    <= EV_BUTTON;
			bidx_q    <= '0;
			press_q   <= 1'b0;
			cx_q      <= '0;
			cy_q      <= '0;
			last_q    <= 1'b0;
		end else begin
			if (out_v_q && out_ch.ready && !out_load) begin
				out_v_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_BOUND_X:   bound_x_q <= cfg_data[BOUND_W-1:0];
					REG_BOUND_Y:   bound_y_q <= cfg_data[BOUND_W-1:0];
					REG_SLOWNESS:  slow_q    <= cfg_data[SLOW_W-1:0];
					REG_EV_ENABLE: begin
						en_q <= cfg_data[0];
						lv_q <= '0;
					end
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && in_ch.from_aux) begin
						unique case (phase_q)
							PH_DX: begin
								dx_q    <= in_ch.data_byte;
								phase_q <= PH_DY;
							end
							PH_DY: begin
								dy_q    <= in_ch.data_byte;
								phase_q <= PH_HEADER;
								state_q <= ST_CLAMP_X;
							end
							default: begin
								if (in_ch.data_byte[HDR_SYNC_BIT]) begin
									hdr_q   <= in_ch.data_byte;
									lv_q    <= in_ch.data_byte[BTN_N-1:0];
									chg_q   <= new_chg;
									phase_q <= PH_DX;
									if (en_q && (new_chg != '0)) begin
										state_q <= ST_BTN;
									end
								end
							end
						endcase
					end
				end
				ST_BTN: begin
					if (out_free) begin
						out_v_q <= 1'b1;
						kind_q  <= EV_BUTTON;
						bidx_q  <= btn_idx;
						press_q <= lv_q[btn_idx];
						cx_q    <= '0;
						cy_q    <= '0;
						last_q  <= (chg_rest == '0);
						chg_q   <= chg_rest;
						if (chg_rest == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_CLAMP_X: begin
					pos_x_q <= clamped;
					state_q <= ST_CLAMP_Y;
				end
				ST_CLAMP_Y: begin
					pos_y_q <= clamped;
					state_q <= en_q ? ST_DIV_GO : ST_IDLE;
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (!busy_x && !busy_y) begin
						state_q <= ST_MOVE;
					end
				end
				ST_MOVE: begin
					if (out_free) begin
						out_v_q <= 1'b1;
						kind_q  <= EV_MOVE;
						bidx_q  <= '0;
						press_q <= 1'b0;
						cx_q    <= quo_x[CUR_W-1:0];
						cy_q    <= quo_y[CUR_W-1:0];
						last_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid          = out_v_q;
	assign out_ch.event_kind     = kind_q;
	assign out_ch.button_index   = bidx_q;
	assign out_ch.button_pressed = press_q;
	assign out_ch.cursor_x       = cx_q;
	assign out_ch.cursor_y       = cy_q;
	assign out_ch.last_event     = last_q;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_x_q <= POS_MAX) && (pos_y_q <= POS_MAX))
		else $error("position beyond largest clamp limit");
	a_btn_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BTN) |-> (chg_q != '0))
		else $error("button scan with nothing to report");
	a_move_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && (kind_q == EV_MOVE)) |-> last_q)
		else $error("move event not marked last");

endmodule

FILE: rtl/ps2m_div.sv
module ps2m_div import ps2m_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [POS_W-1:0]  dividend,
	input  logic [SLOW_W-1:0] divisor,
	output logic              busy,
	output logic [POS_W-1:0]  quotient
);

	localparam int unsigned CNT_W = $clog2(POS_W + 1);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SLOW_W-1:0] rem_q;
	logic [SLOW_W-1:0] dsr_q;
	logic [POS_W-1:0]  shf_q;

	logic [SLOW_W:0]   trial;
	logic              q_bit;
	logic [SLOW_W-1:0] rem_nxt;

	always_comb begin
		trial   = {rem_q, shf_q[POS_W-1]};
		q_bit   = (trial >= {1'b0, dsr_q});
		rem_nxt = q_bit ? SLOW_W'(trial - {1'b0, dsr_q}) : trial[SLOW_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dsr_q  <= SLOW_W'(1);
			shf_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(POS_W);
			rem_q  <= '0;
			dsr_q  <= divisor;
			shf_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			shf_q <= {shf_q[POS_W-2:0], q_bit};
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = shf_q;

	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != '0))
		else $error("divider busy with no steps left");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("divider did not start");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q < dsr_q))
		else $error("partial remainder not below divisor");

endmodule

FILE: tb/sv/tb_ps2_mouse_packet_decoder.sv
module tb_ps2_mouse_packet_decoder;
	import ps2m_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 400000;

	typedef struct {
		logic              kind;
		logic [BIDX_W-1:0] idx;
		logic              pressed;
		logic [CUR_W-1:0]  cx;
		logic [CUR_W-1:0]  cy;
		logic              last;
	} mouse_event_t;

	logic clk;
	logic arst_n;
	logic              cfg_we;
	logic [CFGI_W-1:0] cfg_index;
	logic [CFG_W-1:0]  cfg_data;

	ps2m_in_if  in_if();
	ps2m_out_if out_if();

	ps2_mouse_packet_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_if),
		.out_ch    (out_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// decoder shadow state
	logic [1:0]         pkt_phase;
	logic [BYTE_W-1:0]  hdr_byte;
	logic [BYTE_W-1:0]  xdelta_byte;
	logic [BTN_N-1:0]   btn_levels;
	int                 pos_x;
	int                 pos_y;
	logic [BOUND_W-1:0] lim_x_cfg;
	logic [BOUND_W-1:0] lim_y_cfg;
	logic [SLOW_W-1:0]  slow_cfg;
	logic               events_on;

	mouse_event_t pending_events[$];

	int failures;
	int aux_sent;
	int cycle_count;
	int out_stall;
	bit in_idle;
	bit out_idle;
	bit drift_x;
	bit drift_y;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int eff_slowness();
		return (slow_cfg == 0) ? 1 : int'(slow_cfg);
	endfunction

	function automatic int clamp_position(int v, logic [BOUND_W-1:0] bound);
		int lim;
		lim = int'(bound) * eff_slowness();
		if (v > lim)
			v = lim;
		if (v < 0)
			v = 0;
		return v;
	endfunction

	function automatic void decode_byte(logic [BYTE_W-1:0] b, logic aux);
		int dx;
		int dy;
		int s;
		int produced;
		mouse_event_t ev;
		produced = 0;
		if (!aux)
			return;
		case (pkt_phase)
			PH_DX: begin
				xdelta_byte = b;
				pkt_phase = PH_DY;
			end
			PH_DY: begin
				dx = hdr_byte[HDR_XSIGN] ? int'(xdelta_byte) - 256 : int'(xdelta_byte);
				dy = hdr_byte[HDR_YSIGN] ? int'(b) - 256 : int'(b);
				pos_x = clamp_position(pos_x + dx, lim_x_cfg);
				pos_y = clamp_position(pos_y - dy, lim_y_cfg);
				pkt_phase = PH_HEADER;
				if (events_on) begin
					s = eff_slowness();
					ev.kind = EV_MOVE;
					ev.idx = '0;
					ev.pressed = 1'b0;
					ev.cx = CUR_W'(pos_x / s);
					ev.cy = CUR_W'(pos_y / s);
					ev.last = 1'b1;
					pending_events.push_back(ev);
				end
			end
			default: begin
				if (!b[HDR_SYNC_BIT])
					return;
				hdr_byte = b;
				for (int i = 0; i < BTN_N; i++) begin
					if (btn_levels[i] != b[i]) begin
						btn_levels[i] = b[i];
						if (events_on) begin
							ev.kind = EV_BUTTON;
							ev.idx = BIDX_W'(i);
							ev.pressed = b[i];
							ev.cx = '0;
							ev.cy = '0;
							ev.last = 1'b0;
							pending_events.push_back(ev);
							produced++;
						end
					end
				end
				if (produced > 0)
					pending_events[pending_events.size()-1].last = 1'b1;
				pkt_phase = PH_DX;
			end
		endcase
	endfunction

	function automatic void compare_field(string name, logic [15:0] expv, logic [15:0] actv);
		if (actv !== expv) begin
			$error("%s: expected %0d, actual %0d", name, expv, actv);
			failures++;
		end
	endfunction

	task automatic check_event();
		mouse_event_t ev;
		if (pending_events.size() == 0) begin
			$error("unexpected event: kind %0d button %0d x %0d y %0d",
				out_if.event_kind, out_if.button_index, out_if.cursor_x, out_if.cursor_y);
			failures++;
		end else begin
			ev = pending_events.pop_front();
			compare_field("event_kind", 16'(ev.kind), 16'(out_if.event_kind));
			compare_field("button_index", 16'(ev.idx), 16'(out_if.button_index));
			compare_field("button_pressed", 16'(ev.pressed), 16'(out_if.button_pressed));
			compare_field("cursor_x", 16'(ev.cx), 16'(out_if.cursor_x));
			compare_field("cursor_y", 16'(ev.cy), 16'(out_if.cursor_y));
			compare_field("last_event", 16'(ev.last), 16'(out_if.last_event));
		end
	endtask

	// event sink with random back-pressure
	always @(posedge clk) begin
		if (arst_n && out_if.valid && out_if.ready) begin
			check_event();
			out_stall = out_idle ? $urandom_range(0, 12) : 0;
		end
		if (out_stall > 0) begin
			out_stall--;
			out_if.ready <= 1'b0;
		end else begin
			out_if.ready <= 1'b1;
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("ps2_mouse_packet_decoder test failed");
		$finish;
	end

	task automatic send_byte(logic [BYTE_W-1:0] b, logic aux);
		int gap;
		gap = in_idle ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			in_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.data_byte <= b;
		in_if.from_aux <= aux;
		do @(posedge clk); while (!in_if.ready);
		decode_byte(b, aux);
		if (aux)
			aux_sent++;
	endtask

	task automatic send_packet(logic [BTN_N-1:0] buttons, int dx, int dy, bit noisy);
		logic [BYTE_W-1:0] hdr;
		logic [BYTE_W-1:0] raw_dx;
		logic [BYTE_W-1:0] raw_dy;
		hdr = BYTE_W'($urandom_range(0, 255));
		hdr[BTN_N-1:0] = buttons;
		hdr[HDR_SYNC_BIT] = 1'b1;
		hdr[HDR_XSIGN] = (dx < 0);
		hdr[HDR_YSIGN] = (dy < 0);
		raw_dx = BYTE_W'(dx);
		raw_dy = BYTE_W'(dy);
		send_byte(hdr, 1'b1);
		if (noisy && $urandom_range(0, 5) == 0)
			send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
		send_byte(raw_dx, 1'b1);
		if (noisy && $urandom_range(0, 5) == 0)
			send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
		send_byte(raw_dy, 1'b1);
	endtask

	// drain outstanding events and give the divider time to finish
	task automatic settle();
		in_if.valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFGI_W-1:0] idx, int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_BOUND_X:   lim_x_cfg = BOUND_W'(val);
			REG_BOUND_Y:   lim_y_cfg = BOUND_W'(val);
			REG_SLOWNESS:  slow_cfg = SLOW_W'(val);
			REG_EV_ENABLE: begin
				events_on = val[0];
				btn_levels = '0;
			end
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic test_events_disabled();
		send_packet(3'b101, 30, -20, 0);
		settle();
		write_reg(REG_EV_ENABLE, 1);
	endtask

	task automatic test_button_events();
		send_packet(3'b111, 0, 0, 0);
		send_packet(3'b010, 1, -1, 0);
		send_packet(3'b000, -1, 1, 0);
	endtask

	task automatic test_motion_extremes();
		send_packet(3'b000, 255, -256, 0);
		send_packet(3'b000, -256, 255, 0);
		send_packet(3'b000, 127, -128, 0);
	endtask

	task automatic test_ignored_bytes();
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hF7, 1'b1);
		send_byte(8'h08, 1'b1);
		send_byte(8'h55, 1'b0);
		send_byte(8'h10, 1'b1);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h02, 1'b1);
	endtask

	task automatic test_scaling_and_bounds();
		settle();
		write_reg(REG_SLOWNESS, 0);
		write_reg(REG_BOUND_X, 1023);
		write_reg(REG_BOUND_Y, 0);
		send_packet(3'b001, 255, -256, 0);
		settle();
		write_reg(REG_BOUND_X, 1);
		write_reg(REG_SLOWNESS, 31);
		send_packet(3'b001, 0, 0, 0);
	endtask

	task automatic run_setting(int bx, int by, int slow, int en, int n_items);
		int start;
		int dx;
		int dy;
		settle();
		write_reg(REG_BOUND_X, bx);
		write_reg(REG_BOUND_Y, by);
		write_reg(REG_SLOWNESS, slow);
		write_reg(REG_EV_ENABLE, en);
		drift_x = 1'($urandom_range(0, 1));
		drift_y = 1'($urandom_range(0, 1));
		start = aux_sent;
		while (aux_sent - start < n_items) begin
			if ($urandom_range(0, 29) == 0) begin
				in_idle = ($urandom_range(0, 2) != 0);
				out_idle = ($urandom_range(0, 2) != 0);
			end
			case ($urandom_range(0, 9))
				0: send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
				1: send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
				default: begin
					if ($urandom_range(0, 2) == 0) begin
						dx = drift_x ? 255 : -256;
						dy = drift_y ? 255 : -256;
					end else begin
						dx = int'($urandom_range(0, 511)) - 256;
						dy = int'($urandom_range(0, 511)) - 256;
					end
					send_packet(BTN_N'($urandom_range(0, 7)), dx, dy, 1);
				end
			endcase
		end
	endtask

	task automatic test_random_traffic();
		run_setting(1023, 1023, 31, 1, 55);
		run_setting(0, 0, 1, 1, 55);
		run_setting($urandom_range(0, 1023), $urandom_range(0, 1023),
			$urandom_range(1, 31), 1, 55);
		run_setting($urandom_range(0, 1023), $urandom_range(0, 1023),
			$urandom_range(1, 31), 0, 40);
		run_setting(1023, $urandom_range(0, 1023), 0, 1, 55);
		run_setting($urandom_range(0, 20), $urandom_range(0, 20), 31, 1, 75);
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_BOUND_X;
		cfg_data <= '0;
		in_if.valid <= 1'b0;
		in_if.data_byte <= '0;
		in_if.from_aux <= 1'b0;
		pkt_phase = PH_HEADER;
		hdr_byte = '0;
		xdelta_byte = '0;
		btn_levels = '0;
		pos_x = int'(POS_X_RST);
		pos_y = int'(POS_Y_RST);
		lim_x_cfg = BOUND_X_RST;
		lim_y_cfg = BOUND_Y_RST;
		slow_cfg = SLOW_RST;
		events_on = 1'b0;
		aux_sent = 0;
		in_idle = 1'b1;
		out_idle = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_events_disabled();
		test_button_events();
		test_motion_extremes();
		test_ignored_bytes();
		test_scaling_and_bounds();
		test_random_traffic();

		settle();
		if (failures == 0)
			$display("ps2_mouse_packet_decoder test passed");
		else
			$display("ps2_mouse_packet_decoder test failed");
		$finish;
	end

endmodule
